FILE: design/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked and reset-qualified
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/erhf_pkg.sv
// ---------------------------------------------------------------------------
// erhf_pkg
// types, constants and state encoding for the hole finder
// ---------------------------------------------------------------------------
package erhf_pkg;

    localparam int ADDR_W             = 64;
    localparam int MAX_RANGES_DEFAULT = 16;
    localparam int CFG_IDX_W          = 1;

    localparam logic [ADDR_W-1:0] MEMORY_TOP_RESET = '1;
    localparam logic [ADDR_W-1:0] LOW_LIMIT_RESET  = 64'h0000_0000_3000_0000;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MEMORY_TOP = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_LIMIT  = 1'b1;

    // one stored range, as kept in the range memory
    typedef struct packed {
        logic [ADDR_W-1:0] start_addr;
        logic [ADDR_W-1:0] end_addr;
    } erhf_entry_t;

    localparam int ENTRY_W = $bits(erhf_entry_t);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SORT,
        S_P_RD0,
        S_P_CAR,
        S_P_RDN,
        S_P_CMP,
        S_P_END,
        S_W_RD,
        S_W_DAT,
        S_W_NEXT,
        S_TOP_CHK,
        S_LIM_S,
        S_LIM_E,
        S_PUSH,
        S_FINISH
    } erhf_state_t;

endpackage

FILE: design/erhf_if.sv
// ---------------------------------------------------------------------------
// erhf channel interfaces
// valid/ready channels for range items in and hole items out
// ---------------------------------------------------------------------------
interface erhf_range_if;
    import erhf_pkg::*;

    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] range_start;
    logic [ADDR_W-1:0] range_end;
    logic              last_range;

    modport source (output valid, range_start, range_end, last_range, input ready);
    modport sink   (input valid, range_start, range_end, last_range, output ready);
endinterface

interface erhf_hole_if;
    import erhf_pkg::*;

    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] hole_start;
    logic [ADDR_W-1:0] hole_end;
    logic              no_holes;
    logic              last_hole;

    modport source (output valid, hole_start, hole_end, no_holes, last_hole, input ready);
    modport sink   (input valid, hole_start, hole_end, no_holes, last_hole, output ready);
endinterface

FILE: design/erhf_ram.sv
// ---------------------------------------------------------------------------
// erhf_ram
// generic simple dual-port ram, one write and one registered read port
// ---------------------------------------------------------------------------
module erhf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

FILE: design/exclude_range_hole_finder.sv
// ---------------------------------------------------------------------------
// exclude_range_hole_finder
// finds the free address holes around a set of excluded ranges
// ---------------------------------------------------------------------------
// Excluded ranges arrive one item each and are written to a small range memory
// (up to MAX_RANGES; further ranges are dropped, their last mark still counts).
// The item marked last_range starts a run: the stored ranges are stable-sorted
// by start with bubble passes that carry the larger entry through the memory,
// then walked in order to produce holes. One 64-bit magnitude comparator is
// shared by the sort, the memory-top check and both low-memory-limit checks.
// The memory read is registered, so a sort pass first reads the first entry
// into the carry, then reads each next entry before comparing it with the
// carry, and the walk reads each range before checking it; the walk also
// waits on any output stall. No new range item is taken until the
// last hole item of the run has been handed to the output register. Holes are
// delivered lowest first, last_hole on the final one; if no hole survives, a
// single item with no_holes set and zero addresses is sent. The first hole
// (below the lowest start) is not limited; every later hole starting at or
// above low_memory_limit is dropped and ends the run, one crossing it is
// clipped to the limit and ends the run. A configuration write takes effect
// at once, so registers should only be written while no run is in progress.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module exclude_range_hole_finder #(
    parameter int MAX_RANGES = erhf_pkg::MAX_RANGES_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [erhf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [erhf_pkg::ADDR_W-1:0]    cfg_data,
    erhf_range_if.sink                     ranges,
    erhf_hole_if.source                    holes
);
    import erhf_pkg::*;

    localparam int IDX_W = $clog2(MAX_RANGES);
    localparam int CNT_W = $clog2(MAX_RANGES + 1);

    // sequencer
    erhf_state_t state_reg, state_next;

    // configuration
    logic [ADDR_W-1:0] memory_top_reg, memory_top_next;
    logic [ADDR_W-1:0] low_limit_reg, low_limit_next;

    // counts and indexes
    logic [CNT_W-1:0] count_reg, count_next;   // ranges stored so far
    logic [CNT_W-1:0] n_reg, n_next;           // ranges in this run
    logic [CNT_W-1:0] m_reg, m_next;           // length of current sort pass
    logic [IDX_W-1:0] j_reg, j_next;           // sort position
    logic [IDX_W-1:0] i_reg, i_next;           // walk position

    // datapath
    erhf_entry_t       carry_reg, carry_next;  // entry bubbling up in a pass
    logic [ADDR_W-1:0] prev_end_reg, prev_end_next;
    logic [ADDR_W-1:0] cand_s_reg, cand_s_next;
    logic [ADDR_W-1:0] cand_e_reg, cand_e_next;
    logic              stop_reg, stop_next;

    // one-deep hold of the newest hole, so the last one can be marked
    logic              pend_valid_reg, pend_valid_next;
    logic [ADDR_W-1:0] pend_s_reg, pend_s_next;
    logic [ADDR_W-1:0] pend_e_reg, pend_e_next;

    // output register
    logic              out_valid_reg, out_valid_next;
    logic [ADDR_W-1:0] out_s_reg, out_s_next;
    logic [ADDR_W-1:0] out_e_reg, out_e_next;
    logic              out_none_reg, out_none_next;
    logic              out_last_reg, out_last_next;

    // range memory
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    erhf_entry_t       ram_wdata;
    logic [IDX_W-1:0]  ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;
    erhf_entry_t       rd_entry;

    // shared comparator
    logic [ADDR_W-1:0] cmp_a, cmp_b;
    logic              cmp_gt;

    // misc decode
    logic              in_acc;
    logic              has_room;
    logic              out_free;
    logic              push_done;
    logic              pass_last;
    logic              walk_last;
    logic [ADDR_W-1:0] prev_plus1;
    logic [ADDR_W-1:0] rd_start_m1;

    erhf_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_RANGES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_entry = erhf_entry_t'(ram_rdata);

    assign ranges.ready = (state_reg == S_IDLE);
    assign in_acc       = ranges.valid && ranges.ready;
    assign has_room     = (count_reg < CNT_W'(MAX_RANGES));

    assign holes.valid      = out_valid_reg;
    assign holes.hole_start = out_s_reg;
    assign holes.hole_end   = out_e_reg;
    assign holes.no_holes   = out_none_reg;
    assign holes.last_hole  = out_last_reg;

    assign out_free  = !out_valid_reg || holes.ready;
    assign push_done = !pend_valid_reg || out_free;

    // the bubble has reached the top of the pass
    assign pass_last = ((CNT_W'(j_reg) + CNT_W'(1)) == (m_reg - CNT_W'(1)));
    assign walk_last = (CNT_W'(i_reg) == (n_reg - CNT_W'(1)));

    assign prev_plus1  = prev_end_reg + ADDR_W'(1);
    assign rd_start_m1 = rd_entry.start_addr - ADDR_W'(1);

    assign cmp_gt = (cmp_a > cmp_b);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc && ranges.last_range)
                begin
                    state_next = S_SORT;
                end
            end
            S_SORT:
            begin
                state_next = (n_reg < CNT_W'(2)) ? S_W_RD : S_P_RD0;
            end
            S_P_RD0:   state_next = S_P_CAR;
            S_P_CAR:   state_next = S_P_RDN;
            S_P_RDN:   state_next = S_P_CMP;
            S_P_CMP:
            begin
                state_next = pass_last ? S_P_END : S_P_RDN;
            end
            S_P_END:
            begin
                state_next = ((m_reg - CNT_W'(1)) < CNT_W'(2)) ? S_W_RD : S_P_RD0;
            end
            S_W_RD:    state_next = S_W_DAT;
            S_W_DAT:
            begin
                if (i_reg == '0)
                begin
                    state_next = (rd_entry.start_addr != '0) ? S_PUSH : S_W_NEXT;
                end
                else
                begin
                    state_next = (rd_entry.start_addr == prev_plus1) ? S_W_NEXT : S_LIM_S;
                end
            end
            S_W_NEXT:
            begin
                state_next = walk_last ? S_TOP_CHK : S_W_RD;
            end
            S_TOP_CHK:
            begin
                state_next = cmp_gt ? S_LIM_S : S_FINISH;
            end
            S_LIM_S:
            begin
                state_next = cmp_gt ? S_LIM_E : S_FINISH;
            end
            S_LIM_E:   state_next = S_PUSH;
            S_PUSH:
            begin
                if (push_done)
                begin
                    state_next = stop_reg ? S_FINISH : S_W_NEXT;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:   state_next = S_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        memory_top_next = memory_top_reg;
        low_limit_next  = low_limit_reg;
        count_next      = count_reg;
        n_next          = n_reg;
        m_next          = m_reg;
        j_next          = j_reg;
        i_next          = i_reg;
        carry_next      = carry_reg;
        prev_end_next   = prev_end_reg;
        cand_s_next     = cand_s_reg;
        cand_e_next     = cand_e_reg;
        stop_next       = stop_reg;
        pend_valid_next = pend_valid_reg;
        pend_s_next     = pend_s_reg;
        pend_e_next     = pend_e_reg;
        out_valid_next  = out_valid_reg && !holes.ready;
        out_s_next      = out_s_reg;
        out_e_next      = out_e_reg;
        out_none_next   = out_none_reg;
        out_last_next   = out_last_reg;

        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = carry_reg;
        ram_raddr = '0;
        cmp_a     = '0;
        cmp_b     = '0;

        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MEMORY_TOP: memory_top_next = cfg_data;
                CFG_LOW_LIMIT:  low_limit_next  = cfg_data;
                default:        ;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                ram_waddr            = IDX_W'(count_reg);
                ram_wdata.start_addr = ranges.range_start;
                ram_wdata.end_addr   = ranges.range_end;
                if (in_acc)
                begin
                    ram_we = has_room;
                    if (has_room)
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                    n_next = has_room ? (count_reg + CNT_W'(1)) : count_reg;
                    m_next = n_next;
                end
            end
            S_SORT:
            begin
                i_next = '0;
            end
            S_P_RD0:
            begin
                ram_raddr = '0;
                j_next    = '0;
            end
            S_P_CAR:
            begin
                carry_next = rd_entry;
            end
            S_P_RDN:
            begin
                ram_raddr = IDX_W'(CNT_W'(j_reg) + CNT_W'(1));
            end
            S_P_CMP:
            begin
                // swap only on strictly greater start, which keeps the sort stable
                cmp_a     = carry_reg.start_addr;
                cmp_b     = rd_entry.start_addr;
                ram_we    = 1'b1;
                ram_waddr = j_reg;
                if (cmp_gt)
                begin
                    ram_wdata = rd_entry;
                end
                else
                begin
                    ram_wdata  = carry_reg;
                    carry_next = rd_entry;
                end
                j_next = IDX_W'(CNT_W'(j_reg) + CNT_W'(1));
            end
            S_P_END:
            begin
                ram_we    = 1'b1;
                ram_waddr = IDX_W'(m_reg - CNT_W'(1));
                ram_wdata = carry_reg;
                m_next    = m_reg - CNT_W'(1);
            end
            S_W_RD:
            begin
                ram_raddr = i_reg;
            end
            S_W_DAT:
            begin
                prev_end_next = rd_entry.end_addr;
                stop_next     = 1'b0;
                if (i_reg == '0)
                begin
                    // hole below the lowest range, not limited
                    cand_s_next = '0;
                    cand_e_next = rd_start_m1;
                end
                else
                begin
                    cand_s_next = prev_plus1;
                    cand_e_next = rd_start_m1;
                end
            end
            S_W_NEXT:
            begin
                if (!walk_last)
                begin
                    i_next = IDX_W'(CNT_W'(i_reg) + CNT_W'(1));
                end
            end
            S_TOP_CHK:
            begin
                cmp_a       = memory_top_reg;
                cmp_b       = prev_end_reg;
                cand_s_next = prev_plus1;
                cand_e_next = memory_top_reg;
                stop_next   = 1'b1;
            end
            S_LIM_S:
            begin
                // start at or above the limit: dropped, run ends
                cmp_a = low_limit_reg;
                cmp_b = cand_s_reg;
            end
            S_LIM_E:
            begin
                cmp_a = low_limit_reg;
                cmp_b = cand_e_reg;
                if (!cmp_gt)
                begin
                    cand_e_next = low_limit_reg;
                    stop_next   = 1'b1;
                end
            end
            S_PUSH:
            begin
                if (push_done)
                begin
                    if (pend_valid_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_s_next     = pend_s_reg;
                        out_e_next     = pend_e_reg;
                        out_none_next  = 1'b0;
                        out_last_next  = 1'b0;
                    end
                    pend_valid_next = 1'b1;
                    pend_s_next     = cand_s_reg;
                    pend_e_next     = cand_e_reg;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_s_next      = pend_valid_reg ? pend_s_reg : '0;
                    out_e_next      = pend_valid_reg ? pend_e_reg : '0;
                    out_none_next   = !pend_valid_reg;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                    count_next      = '0;
                end
            end
            default:   ;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            memory_top_reg <= MEMORY_TOP_RESET;
            low_limit_reg  <= LOW_LIMIT_RESET;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            memory_top_reg <= memory_top_next;
            low_limit_reg  <= low_limit_next;
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload and working registers
    always_ff @(posedge clk)
    begin
        n_reg        <= n_next;
        m_reg        <= m_next;
        j_reg        <= j_next;
        i_reg        <= i_next;
        carry_reg    <= carry_next;
        prev_end_reg <= prev_end_next;
        cand_s_reg   <= cand_s_next;
        cand_e_reg   <= cand_e_next;
        stop_reg     <= stop_next;
        pend_s_reg   <= pend_s_next;
        pend_e_reg   <= pend_e_next;
        out_s_reg    <= out_s_next;
        out_e_reg    <= out_e_next;
        out_none_reg <= out_none_next;
        out_last_reg <= out_last_next;
    end

    // no held hole may survive into the load phase
    `ASSERT_IMPL(a_idle_no_pend, clk, rst_n, ranges.ready, !pend_valid_reg,
        "hole still held while taking ranges")
    // an empty-run item carries zero addresses and ends the run
    `ASSERT_IMPL(a_none_shape, clk, rst_n, out_valid_reg && out_none_reg,
        out_last_reg && (out_s_reg == '0) && (out_e_reg == '0),
        "malformed no-hole item")
    // store count never passes its capacity
    `ASSERT_IMPL(a_count_cap, clk, rst_n, 1'b1, count_reg <= CNT_W'(MAX_RANGES),
        "range count overflow")
    // closing the run empties the store and returns to loading
    `ASSERT_NEXT(a_finish_idle, clk, rst_n, (state_reg == S_FINISH) && out_free,
        (state_reg == S_IDLE) && (count_reg == '0) && out_valid_reg && out_last_reg,
        "run did not close cleanly")
endmodule

FILE: tb/erhf_checker.sv
// ---------------------------------------------------------------------------
// erhf_checker
// watches the range and hole channels and the configuration port, keeps its
// own copy of the stored ranges and registers, works out the holes of every
// run and compares each hole item taken from the block with the oldest one
// ---------------------------------------------------------------------------
module erhf_checker #(
    parameter int MAX_RANGES = erhf_pkg::MAX_RANGES_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [erhf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [erhf_pkg::ADDR_W-1:0]    cfg_data,
    erhf_range_if                          ranges,
    erhf_hole_if                           holes,
    output int                             pending_holes,
    output int                             failures
);
    timeunit 1ns;
    timeprecision 1ps;

    import erhf_pkg::*;

    localparam int MAX_PRINTED = 40;

    typedef struct packed {
        logic [ADDR_W-1:0] hole_start;
        logic [ADDR_W-1:0] hole_end;
        logic              no_holes;
        logic              last_hole;
    } hole_item_t;

    logic [ADDR_W-1:0] mem_top;
    logic [ADDR_W-1:0] low_limit;
    erhf_entry_t       stored_ranges[$];
    hole_item_t        expected_holes[$];

    task automatic report(input string msg);
        if (failures < MAX_PRINTED)
            $display("%0t: hole mismatch: %s", $time, msg);
        failures++;
    endtask

    function automatic hole_item_t make_hole(input logic [ADDR_W-1:0] s,
                                             input logic [ADDR_W-1:0] e);
        make_hole = '{s, e, 1'b0, 1'b0};
    endfunction

    // sort the stored ranges and queue up the holes of the run
    task automatic find_holes();
        erhf_entry_t       sorted_ranges[$];
        erhf_entry_t       moving;
        hole_item_t        found[$];
        logic [ADDR_W-1:0] hs;
        logic [ADDR_W-1:0] he;
        int                n;
        int                j;
        sorted_ranges = stored_ranges;
        n = sorted_ranges.size();
        // insertion sort keeps equal starts in arrival order
        for (int i = 1; i < n; i++)
        begin
            moving = sorted_ranges[i];
            j = i;
            while (j > 0 && sorted_ranges[j-1].start_addr > moving.start_addr)
            begin
                sorted_ranges[j] = sorted_ranges[j-1];
                j--;
            end
            sorted_ranges[j] = moving;
        end
        // hole below the lowest start is never limited
        if (n > 0 && sorted_ranges[0].start_addr != 64'd0)
            found.push_back(make_hole(64'd0, sorted_ranges[0].start_addr - 64'd1));
        for (int i = 0; i < n; i++)
        begin
            hs = sorted_ranges[i].end_addr + 64'd1;
            if (i == n - 1)
            begin
                if (sorted_ranges[i].end_addr >= mem_top)
                    break;
                he = mem_top;
            end
            else
            begin
                if (sorted_ranges[i+1].start_addr == hs)
                    continue;
                he = sorted_ranges[i+1].start_addr - 64'd1;
            end
            if (hs >= low_limit)
                break;
            if (he >= low_limit)
            begin
                found.push_back(make_hole(hs, low_limit));
                break;
            end
            found.push_back(make_hole(hs, he));
        end
        if (found.size() == 0)
            found.push_back('{64'd0, 64'd0, 1'b1, 1'b0});
        found[found.size()-1].last_hole = 1'b1;
        foreach (found[k])
            expected_holes.push_back(found[k]);
    endtask

    task automatic check_hole();
        hole_item_t want;
        if (expected_holes.size() == 0)
        begin
            report($sformatf("unexpected item start=%h end=%h", holes.hole_start,
                             holes.hole_end));
            return;
        end
        want = expected_holes.pop_front();
        if (holes.hole_start !== want.hole_start)
            report($sformatf("hole_start %h, expected %h", holes.hole_start, want.hole_start));
        if (holes.hole_end !== want.hole_end)
            report($sformatf("hole_end %h, expected %h", holes.hole_end, want.hole_end));
        if (holes.no_holes !== want.no_holes)
            report($sformatf("no_holes %b, expected %b", holes.no_holes, want.no_holes));
        if (holes.last_hole !== want.last_hole)
            report($sformatf("last_hole %b, expected %b", holes.last_hole, want.last_hole));
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            mem_top   = MEMORY_TOP_RESET;
            low_limit = LOW_LIMIT_RESET;
            stored_ranges.delete();
            expected_holes.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_MEMORY_TOP)
                    mem_top = cfg_data;
                else if (cfg_index == CFG_LOW_LIMIT)
                    low_limit = cfg_data;
            end
            if (holes.valid && holes.ready)
                check_hole();
            if (ranges.valid && ranges.ready)
            begin
                // a full store drops the range, the last mark still counts
                if (stored_ranges.size() < MAX_RANGES)
                    stored_ranges.push_back('{ranges.range_start, ranges.range_end});
                if (ranges.last_range)
                begin
                    find_holes();
                    stored_ranges.delete();
                end
            end
        end
        pending_holes <= expected_holes.size();
    end

endmodule

FILE: tb/tb.sv
// ---------------------------------------------------------------------------
// tb
// stimulus and verdict for the hole finder
// ---------------------------------------------------------------------------
// Runs of excluded ranges go in, the last item of each run marked. A short
// directed part covers the edge cases under the reset configuration; then
// phases with different memory tops and low-memory limits send random runs,
// mostly well-formed address maps in shuffled order, some pure noise. The
// checker beside the block predicts and compares every hole item.
// ---------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import erhf_pkg::*;

    localparam int RANDOM_ITEMS = 250;   // random part stops after this many
    localparam int PHASE_ITEMS  = 35;    // items per configuration phase
    localparam int LONG_HOLD    = 400;   // cycles of the long output hold-off
    localparam int IDLE_LIMIT   = 5000;  // watchdog, cycles with no handshake
    localparam int SETTLE       = 8;     // quiet cycles before a config write
    localparam int END_WAIT     = 40;    // quiet cycles before the verdict

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [ADDR_W-1:0]    cfg_data;

    erhf_range_if ranges ();
    erhf_hole_if  holes ();

    int pending_holes;
    int failures;
    int items_sent    = 0;
    int burst_left    = 0;
    bit gaps_on       = 1'b1;
    int hold_requests = 0;
    int stalled_cycles = 0;

    exclude_range_hole_finder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .ranges    (ranges),
        .holes     (holes)
    );

    erhf_checker hole_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .ranges        (ranges),
        .holes         (holes),
        .pending_holes (pending_holes),
        .failures      (failures)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // watchdog: too long without any handshake or config write ends the run
    always @(posedge clk)
    begin
        if ((ranges.valid && ranges.ready) || (holes.valid && holes.ready) || cfg_we)
            stalled_cycles <= 0;
        else if (stalled_cycles >= IDLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
        else
            stalled_cycles <= stalled_cycles + 1;
    end

    // output side: ready follows a pattern that changes now and then, with
    // stretches of always-ready, and a long hold-off on request
    initial
    begin : hole_receiver
        int          hold_left;
        int          hold_served;
        int          mode;
        int          mode_left;
        logic [31:0] pattern;
        hold_left   = 0;
        hold_served = 0;
        mode        = 0;
        mode_left   = 0;
        pattern     = '1;
        holes.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                holes.ready <= 1'b0;
            end
            else if (hold_served != hold_requests)
            begin
                // block fills up behind this while the sender keeps offering
                hold_served = hold_requests;
                hold_left   = LONG_HOLD;
                holes.ready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = $urandom_range(0, 2);
                    mode_left = $urandom_range(8, 120);
                    pattern   = $urandom;
                end
                mode_left--;
                case (mode)
                    0: holes.ready <= 1'b1;
                    1:
                    begin
                        holes.ready <= pattern[0];
                        pattern = {pattern[0], pattern[31:1]};
                    end
                    default: holes.ready <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    // offer one range item and wait until it is taken; the sender works in
    // bursts, a gap may come before a new burst
    task automatic offer_range(input logic [ADDR_W-1:0] s, input logic [ADDR_W-1:0] e,
                               input logic last);
        int gap;
        if (burst_left == 0)
        begin
            gap = gaps_on ? $urandom_range(0, 10) : 0;
            burst_left = $urandom_range(1, 24);
            if (gap != 0)
            begin
                ranges.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        ranges.valid       <= 1'b1;
        ranges.range_start <= s;
        ranges.range_end   <= e;
        ranges.last_range  <= last;
        do
            @(posedge clk);
        while (!ranges.ready);
        items_sent++;
    endtask

    // stop offering and wait until every expected hole item has come
    task automatic drain(input int settle);
        ranges.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_holes != 0);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_config(input logic [ADDR_W-1:0] top_val,
                                input logic [ADDR_W-1:0] limit_val);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_MEMORY_TOP;
        cfg_data  <= top_val;
        @(posedge clk);
        cfg_index <= CFG_LOW_LIMIT;
        cfg_data  <= limit_val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // one run of ranges: either an ordered address map built upward from a
    // random base, then shuffled, or fully random start/end pairs
    task automatic send_run(input int count, input bit noisy);
        logic [ADDR_W-1:0] starts[$];
        logic [ADDR_W-1:0] ends[$];
        logic [ADDR_W-1:0] cursor;
        logic [ADDR_W-1:0] mask;
        logic [ADDR_W-1:0] s;
        logic [ADDR_W-1:0] e;
        int                k;
        mask   = (64'd1 << $urandom_range(4, 62)) - 64'd1;
        cursor = ($urandom_range(0, 3) == 0) ? 64'd0 : ({$urandom, $urandom} & mask);
        for (int i = 0; i < count; i++)
        begin
            if (noisy)
            begin
                s = {$urandom, $urandom};
                e = {$urandom, $urandom};
            end
            else
            begin
                case ($urandom_range(0, 7))
                    0: s = cursor;                                        // touching
                    1: s = (i > 0) ? starts[i-1] : cursor;                // same start
                    default: s = cursor + ({$urandom, $urandom} & mask);
                endcase
                e = s + ({$urandom, $urandom} & (mask >> 2));
                cursor = e + 64'd1;
            end
            starts.push_back(s);
            ends.push_back(e);
        end
        // shuffle arrival order, the block has to sort
        for (int i = count - 1; i > 0; i--)
        begin
            k = $urandom_range(0, i);
            s = starts[i];
            e = ends[i];
            starts[i] = starts[k];
            ends[i]   = ends[k];
            starts[k] = s;
            ends[k]   = e;
        end
        for (int i = 0; i < count; i++)
            offer_range(starts[i], ends[i], i == count - 1);
    endtask

    initial
    begin : stimulus
        int                phase;
        int                runs;
        int                phase_start;
        int                size_pick;
        int                run_size;
        logic [ADDR_W-1:0] top_val;
        logic [ADDR_W-1:0] limit_val;

        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = CFG_MEMORY_TOP;
        cfg_data           = '0;
        ranges.valid       = 1'b0;
        ranges.range_start = '0;
        ranges.range_end   = '0;
        ranges.last_range  = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed part, reset configuration ----
        // one range covering all of memory: no hole at all
        offer_range(64'd0, '1, 1'b1);
        // touching ranges skip a hole; final hole clipped to the limit
        offer_range(64'h1_0000, 64'h1_FFFF, 1'b0);
        offer_range(64'h1000, 64'h1FFF, 1'b0);
        offer_range(64'h2000, 64'h2FFF, 1'b1);
        // later hole starting right at the limit is dropped
        offer_range(64'h4000_0000, 64'h4FFF_FFFF, 1'b0);
        offer_range(64'h100, 64'h2FFF_FFFF, 1'b1);
        // range ending at the top wraps the next hole start to zero
        offer_range(64'h20, 64'h30, 1'b0);
        offer_range(64'h10, '1, 1'b1);
        // overlapping and reversed ranges give holes with start above end
        offer_range(64'h200, 64'h300, 1'b0);
        offer_range(64'h100, 64'h900, 1'b0);
        offer_range(64'h5000, 64'h1000, 1'b1);
        // full store with repeated starts; the extra last range is dropped
        for (int i = 0; i < MAX_RANGES_DEFAULT; i++)
            offer_range(64'h1_0000 * (((i * 5) % 15) + 1),
                        64'h1_0000 * (((i * 5) % 15) + 1) + 64'h1000 * (i + 1), 1'b0);
        offer_range(64'd0, 64'h8, 1'b1);

        // ---- random part, one configuration per phase ----
        phase = 0;
        runs  = 0;
        phase_start = items_sent;
        while (items_sent < phase_start + RANDOM_ITEMS)
        begin
            // sender pauses until every hole has come before reconfiguring
            drain(SETTLE);
            case (phase % 6)
                0:
                begin
                    top_val   = '1;
                    limit_val = '1;
                end
                1:
                begin
                    top_val   = '0;
                    limit_val = '0;
                end
                2:
                begin
                    top_val   = '1;
                    limit_val = LOW_LIMIT_RESET;
                end
                3:
                begin
                    top_val   = {$urandom, $urandom};
                    limit_val = {$urandom, $urandom};
                end
                4:
                begin
                    top_val   = {$urandom, $urandom} >> $urandom_range(0, 40);
                    limit_val = '1;
                end
                default:
                begin
                    top_val   = '1;
                    limit_val = {$urandom, $urandom} >> $urandom_range(0, 40);
                end
            endcase
            write_config(top_val, limit_val);
            gaps_on = (phase % 3 != 2);
            begin : one_phase
                int phase_items;
                phase_items = items_sent;
                while (items_sent < phase_items + PHASE_ITEMS &&
                       items_sent < phase_start + RANDOM_ITEMS)
                begin
                    // long output hold-off a couple of times during the run
                    if (runs == 4 || runs == 30)
                        hold_requests++;
                    // mostly small runs, now and then a nearly full, full or overfull store
                    size_pick = $urandom_range(0, 19);
                    if (size_pick < 13)
                        run_size = $urandom_range(1, 4);
                    else if (size_pick < 18)
                        run_size = $urandom_range(5, 12);
                    else
                        run_size = $urandom_range(15, 18);
                    send_run(run_size, $urandom_range(0, 4) == 0);
                    runs++;
                end
            end
            phase++;
        end

        drain(END_WAIT);
        if (failures == 0 && pending_holes == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

FILE: files.f
+incdir+design
design/erhf_pkg.sv
design/erhf_if.sv
design/erhf_ram.sv
design/exclude_range_hole_finder.sv
tb/erhf_checker.sv
tb/tb.sv
